>>> src/tekd_pkg.sv
// Package for the terminal escape key decoder: parse modes, key codes, decode result type.
package tekd_pkg;

  // Parse modes of the escape-sequence decoder
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_BR   = 3'd2,
    MODE_BR2  = 3'd3,
    MODE_NUM  = 3'd4
  } mode_t;

  // Control bytes
  localparam logic [7:0] BYTE_CTRL_C = 8'h03;
  localparam logic [7:0] BYTE_CR     = 8'h0d;
  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_LBRACK = 8'h5b;
  localparam logic [7:0] BYTE_TILDE  = 8'h7e;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_NINE   = 8'h39;
  localparam logic [7:0] BYTE_UP_A   = 8'h41;
  localparam logic [7:0] BYTE_UP_D   = 8'h44;
  localparam logic [7:0] BYTE_UP_E   = 8'h45;
  localparam logic [7:0] BYTE_UP_Z   = 8'h5a;
  localparam logic [7:0] BYTE_LO_A   = 8'h61;
  localparam logic [7:0] BYTE_LO_Z   = 8'h7a;

  // Event kinds
  localparam logic EV_KEY   = 1'b0;
  localparam logic EV_CLOSE = 1'b1;

  // Key codes
  localparam logic [8:0] KC_RETURN = 9'd256;
  localparam logic [8:0] KC_ESCAPE = 9'd257;
  localparam logic [8:0] KC_UP     = 9'd258;
  localparam logic [8:0] KC_F1     = 9'd262;
  localparam logic [8:0] KC_F6     = 9'd267;
  localparam logic [8:0] KC_F11    = 9'd272;
  localparam logic [8:0] KC_MAX    = 9'd273;

  // VT220 tilde-number ranges
  localparam logic [7:0] NUM_F1_LO  = 8'd11;
  localparam logic [7:0] NUM_F5_HI  = 8'd15;
  localparam logic [7:0] NUM_F6_LO  = 8'd17;
  localparam logic [7:0] NUM_F10_HI = 8'd21;
  localparam logic [7:0] NUM_F11_LO = 8'd23;
  localparam logic [7:0] NUM_F12_HI = 8'd24;
  localparam logic [7:0] NUM_SAT    = 8'd255;

  // One decoded result
  typedef struct packed {
    logic       emit;
    logic       event_kind;
    logic [8:0] key_code;
  } dec_t;

endpackage

>>> src/tekd_if.sv
// Valid/ready channel interfaces for raw bytes in and key events out.
interface tekd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface tekd_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [8:0] key_code;

  modport source (output valid, output event_kind, output key_code, input ready);
  modport sink   (input valid, input event_kind, input key_code, output ready);
endinterface

>>> src/tekd_in_reg.sv
// Input register stage: holds one raw byte until the decoder takes it.
module tekd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  tekd_in_if.sink    in_ch,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);
  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       accept;

  // Free when empty or when the held byte moves on this cycle
  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.byte_in;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
endmodule

>>> src/tekd_decode.sv
// Combinational decode of one byte against the parse mode and decimal accumulator.
module tekd_decode (
  input  tekd_pkg::mode_t mode,
  input  logic [7:0]      acc,
  input  logic [7:0]      byte_in,
  output tekd_pkg::mode_t mode_nxt,
  output logic [7:0]      acc_nxt,
  output tekd_pkg::dec_t  res
);
  import tekd_pkg::*;

  logic        is_digit;
  logic        is_alnum;
  logic [3:0]  digit;
  logic [11:0] acc_mul;
  logic [11:0] acc_sum;
  logic [8:0]  acc_w;

  assign is_digit = (byte_in >= BYTE_ZERO) && (byte_in <= BYTE_NINE);
  assign is_alnum = is_digit
                 || ((byte_in >= BYTE_UP_A) && (byte_in <= BYTE_UP_Z))
                 || ((byte_in >= BYTE_LO_A) && (byte_in <= BYTE_LO_Z));
  assign digit    = byte_in[3:0];
  assign acc_w    = {1'b0, acc};

  // acc * 10 + digit, saturating at 255
  assign acc_mul = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
  assign acc_sum = acc_mul + {8'd0, digit};

  always_comb begin
    mode_nxt       = mode;
    acc_nxt        = acc;
    res.emit       = 1'b0;
    res.event_kind = EV_KEY;
    res.key_code   = {1'b0, byte_in};

    if (byte_in == BYTE_CTRL_C) begin
      // Close request in any mode
      mode_nxt       = MODE_IDLE;
      res.emit       = 1'b1;
      res.event_kind = EV_CLOSE;
      res.key_code   = 9'd0;
    end else if (byte_in == BYTE_SPACE) begin
      mode_nxt = MODE_IDLE;
      res.emit = 1'b1;
    end else if (byte_in == BYTE_CR) begin
      mode_nxt     = MODE_IDLE;
      res.emit     = 1'b1;
      res.key_code = KC_RETURN;
    end else if (byte_in == BYTE_ESC) begin
      // Second ESC in a row is the escape key itself
      if (mode == MODE_ESC) begin
        res.emit     = 1'b1;
        res.key_code = KC_ESCAPE;
      end else begin
        mode_nxt = MODE_ESC;
      end
    end else begin
      unique case (mode)
        MODE_ESC: begin
          mode_nxt = (byte_in == BYTE_LBRACK) ? MODE_BR : MODE_IDLE;
        end
        MODE_BR: begin
          mode_nxt = MODE_IDLE;
          if ((byte_in >= BYTE_UP_A) && (byte_in <= BYTE_UP_D)) begin
            res.emit     = 1'b1;
            res.key_code = KC_UP + {1'b0, byte_in - BYTE_UP_A};
          end else if (byte_in == BYTE_LBRACK) begin
            mode_nxt = MODE_BR2;
          end else if (is_digit) begin
            mode_nxt = MODE_NUM;
            acc_nxt  = {4'd0, digit};
          end
        end
        MODE_BR2: begin
          mode_nxt = MODE_IDLE;
          if ((byte_in >= BYTE_UP_A) && (byte_in <= BYTE_UP_E)) begin
            res.emit     = 1'b1;
            res.key_code = KC_F1 + {1'b0, byte_in - BYTE_UP_A};
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            acc_nxt = (acc_sum > {4'd0, NUM_SAT}) ? NUM_SAT : acc_sum[7:0];
          end else begin
            mode_nxt = MODE_IDLE;
            if (byte_in == BYTE_TILDE) begin
              // VT220 numbering, gaps at 16 and 22
              if ((acc >= NUM_F1_LO) && (acc <= NUM_F5_HI)) begin
                res.emit     = 1'b1;
                res.key_code = KC_F1 + acc_w - {1'b0, NUM_F1_LO};
              end else if ((acc >= NUM_F6_LO) && (acc <= NUM_F10_HI)) begin
                res.emit     = 1'b1;
                res.key_code = KC_F6 + acc_w - {1'b0, NUM_F6_LO};
              end else if ((acc >= NUM_F11_LO) && (acc <= NUM_F12_HI)) begin
                res.emit     = 1'b1;
                res.key_code = KC_F11 + acc_w - {1'b0, NUM_F11_LO};
              end
            end
          end
        end
        default: begin
          // Idle: letters and digits pass through
          mode_nxt = MODE_IDLE;
          res.emit = is_alnum;
        end
      endcase
    end
  end
endmodule

>>> src/tekd_out_reg.sv
// Result register stage: holds one key event until the receiver takes it.
module tekd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  tekd_pkg::dec_t res,
  output logic           free,
  tekd_out_if.source     out_ch
);
  logic       valid_r;
  logic       valid_nxt;
  logic       kind_r;
  logic [8:0] code_r;
  logic       load;

  assign free = !valid_r || out_ch.ready;
  assign load = advance && res.emit;

  always_comb begin
    if (advance) begin
      valid_nxt = res.emit;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.event_kind;
      code_r <= res.key_code;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.event_kind = kind_r;
  assign out_ch.key_code   = code_r;
endmodule

>>> src/terminal_escape_key_decoder_top.sv
// Top level of the terminal escape key decoder: input register, decoder, result register.
//
// Usage:
//   in_ch  (sink)  : one raw terminal byte per item on byte_in.
//   out_ch (source): zero or one key event per input byte, with event_kind
//                    (0 key press, 1 close request) and a 9-bit key_code.
//   Items move on valid && ready at the rising edge of clk.
// Path: a byte accepted into the input register passes the decoder into the
//   result register (two registers: input, then result) and then shows its
//   event on out_ch. Bytes that make no event produce nothing on out_ch.
// Throughput: one byte per cycle while out_ch is not stalled; the parse mode and
//   decimal accumulator are updated in the same cycle the byte passes the decoder,
//   so the next byte sees them at once.
// Reset (rst_n low, synchronous): both stages empty, parse mode idle,
//   accumulator zero.
// Stall: while a result waits with out_ch.ready low, the held input byte
//   waits too and in_ch.ready stays high only while the input register is
//   empty; no item is dropped or repeated.
module terminal_escape_key_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  tekd_in_if.sink    in_ch,
  tekd_out_if.source out_ch
);
  import tekd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       advance;
  mode_t      mode_r;
  mode_t      mode_nxt;
  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  dec_t       res;

  // Byte moves from input register through the decoder
  assign advance = s1_valid && out_free;

  tekd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  tekd_decode u_decode (
    .mode     (mode_r),
    .acc      (acc_r),
    .byte_in  (s1_byte),
    .mode_nxt (mode_nxt),
    .acc_nxt  (acc_nxt),
    .res      (res)
  );

  // Parse state, updated only when a byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= 8'd0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  tekd_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .res     (res),
    .free    (out_free),
    .out_ch  (out_ch)
  );

  // A close event always carries key code zero
  a_close_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.event_kind == EV_CLOSE) |-> (out_ch.key_code == 9'd0))
    else $error("close event with nonzero key code");

  // Key codes stay inside the defined range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.key_code <= KC_MAX))
    else $error("key code out of range");

  // Ctrl-C returns the parser to idle
  a_ctrl_c_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_byte == BYTE_CTRL_C) |=> (mode_r == MODE_IDLE))
    else $error("parser not idle after Ctrl-C");

  // A blocked result holds the pending byte and parse state
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && out_ch.valid && !out_ch.ready
      |=> s1_valid && $stable(s1_byte) && $stable(mode_r) && $stable(acc_r))
    else $error("pending byte or parse state changed while stalled");

endmodule

>>> dv/terminal_escape_key_decoder_top_tb.sv
// Self-checking testbench for the terminal escape key decoder: byte stream in, key events out.
module terminal_escape_key_decoder_top_tb;
  import tekd_pkg::*;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int DRAIN_LIMIT   = 1000;
  localparam int IDLE_PCT      = 15;
  localparam int QUIET_FROM    = 250;
  localparam int QUIET_TO      = 450;
  localparam int RANDOM_FIRST  = 200;
  localparam int RANDOM_SECOND = 250;

  logic clk;
  logic rst_n;

  tekd_in_if  in_if();
  tekd_out_if out_if();

  terminal_escape_key_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Decoder state mirrored on the testbench side
  mode_t      key_mode;
  logic [7:0] digit_acc;

  logic [7:0] pending_bytes [$];
  dec_t       expected_keys [$];
  int         bytes_queued;
  int         error_count;
  int         cycle_count;

  // Short directed opening: passthrough, drops, controls, escape key, arrow,
  // bracket F-key, tilde F-key and a saturated number
  logic [7:0] opening_bytes [27] = '{
    BYTE_UP_A, BYTE_LO_Z, BYTE_ZERO, 8'h00, 8'hff,
    BYTE_CTRL_C, BYTE_SPACE, BYTE_CR,
    BYTE_ESC, BYTE_ESC, BYTE_LBRACK, BYTE_UP_A,
    BYTE_ESC, BYTE_LBRACK, BYTE_LBRACK, BYTE_UP_E,
    BYTE_ESC, BYTE_LBRACK, BYTE_ZERO + 8'd2, BYTE_ZERO + 8'd4, BYTE_TILDE,
    BYTE_ESC, BYTE_LBRACK, BYTE_NINE, BYTE_NINE, BYTE_NINE, BYTE_TILDE
  };

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit is_digit_byte(input logic [7:0] b);
    return b >= BYTE_ZERO && b <= BYTE_NINE;
  endfunction

  // Next key event for one byte; advances the mirrored parse state
  function automatic dec_t decode_key_byte(input logic [7:0] b);
    dec_t       ev;
    logic [11:0] prod;
    ev = '0;
    ev.event_kind = EV_KEY;
    if (b == BYTE_CTRL_C) begin
      key_mode = MODE_IDLE;
      ev.emit = 1'b1;
      ev.event_kind = EV_CLOSE;
    end else if (b == BYTE_SPACE) begin
      key_mode = MODE_IDLE;
      ev.emit = 1'b1;
      ev.key_code = {1'b0, b};
    end else if (b == BYTE_CR) begin
      key_mode = MODE_IDLE;
      ev.emit = 1'b1;
      ev.key_code = KC_RETURN;
    end else if (b == BYTE_ESC) begin
      // second ESC is the escape key; mode stays after ESC
      if (key_mode == MODE_ESC) begin
        ev.emit = 1'b1;
        ev.key_code = KC_ESCAPE;
      end else begin
        key_mode = MODE_ESC;
      end
    end else begin
      case (key_mode)
        MODE_ESC: begin
          if (b == BYTE_LBRACK) key_mode = MODE_BR;
          else key_mode = MODE_IDLE;
        end
        MODE_BR: begin
          key_mode = MODE_IDLE;
          if (b >= BYTE_UP_A && b <= BYTE_UP_D) begin
            ev.emit = 1'b1;
            ev.key_code = KC_UP + 9'(b - BYTE_UP_A);
          end else if (b == BYTE_LBRACK) begin
            key_mode = MODE_BR2;
          end else if (is_digit_byte(b)) begin
            key_mode = MODE_NUM;
            digit_acc = b - BYTE_ZERO;
          end
        end
        MODE_BR2: begin
          key_mode = MODE_IDLE;
          if (b >= BYTE_UP_A && b <= BYTE_UP_E) begin
            ev.emit = 1'b1;
            ev.key_code = KC_F1 + 9'(b - BYTE_UP_A);
          end
        end
        MODE_NUM: begin
          if (is_digit_byte(b)) begin
            // decimal accumulate, clamp at the top
            prod = 12'(digit_acc) * 12'd10 + 12'(b - BYTE_ZERO);
            digit_acc = (prod > 12'(NUM_SAT)) ? NUM_SAT : prod[7:0];
          end else begin
            key_mode = MODE_IDLE;
            if (b == BYTE_TILDE) begin
              if (digit_acc >= NUM_F1_LO && digit_acc <= NUM_F5_HI) begin
                ev.emit = 1'b1;
                ev.key_code = KC_F1 + 9'(digit_acc - NUM_F1_LO);
              end else if (digit_acc >= NUM_F6_LO && digit_acc <= NUM_F10_HI) begin
                ev.emit = 1'b1;
                ev.key_code = KC_F6 + 9'(digit_acc - NUM_F6_LO);
              end else if (digit_acc >= NUM_F11_LO && digit_acc <= NUM_F12_HI) begin
                ev.emit = 1'b1;
                ev.key_code = KC_F11 + 9'(digit_acc - NUM_F11_LO);
              end
            end
          end
        end
        default: begin
          // idle: letters and digits pass through
          key_mode = MODE_IDLE;
          if (is_digit_byte(b) || (b >= BYTE_UP_A && b <= BYTE_UP_Z) ||
              (b >= BYTE_LO_A && b <= BYTE_LO_Z)) begin
            ev.emit = 1'b1;
            ev.key_code = {1'b0, b};
          end
        end
      endcase
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic bit take_break();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(2))
      0: return 8'($urandom_range(BYTE_ZERO, BYTE_NINE));
      1: return 8'($urandom_range(BYTE_UP_A, BYTE_UP_Z));
      default: return 8'($urandom_range(BYTE_LO_A, BYTE_LO_Z));
    endcase
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(2))
      0: return BYTE_CTRL_C;
      1: return BYTE_SPACE;
      default: return BYTE_CR;
    endcase
  endfunction

  // Mostly well-formed escape sequences with random content, plus noise
  task automatic queue_random_bytes(input int n_items);
    int target;
    int pick;
    int ndig;
    int num;
    target = bytes_queued + n_items;
    while (bytes_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_byte(8'($urandom_range(255)));
      end else if (pick < 24) begin
        push_byte(pick_alnum());
      end else if (pick < 38) begin
        push_byte(BYTE_ESC);
        push_byte(BYTE_LBRACK);
        push_byte(8'($urandom_range(BYTE_UP_A - 1, BYTE_UP_E)));
      end else if (pick < 50) begin
        push_byte(BYTE_ESC);
        push_byte(BYTE_LBRACK);
        push_byte(BYTE_LBRACK);
        push_byte(8'($urandom_range(BYTE_UP_A - 1, BYTE_UP_E + 1)));
      end else if (pick < 78) begin
        // tilde sequence: 1-4 digits, two-digit ones mostly near the F-key numbers; some long or odd ones
        push_byte(BYTE_ESC);
        push_byte(BYTE_LBRACK);
        ndig = $urandom_range(1, 4);
        if (ndig == 2 && $urandom_range(3) != 0) begin
          num = $urandom_range(10, 25);
          push_byte(BYTE_ZERO + 8'(num / 10));
          push_byte(BYTE_ZERO + 8'(num % 10));
        end else begin
          repeat (ndig) push_byte(8'($urandom_range(BYTE_ZERO, BYTE_NINE)));
        end
        if ($urandom_range(4) != 0) push_byte(BYTE_TILDE);
        else push_byte(8'($urandom_range(255)));
      end else if (pick < 86) begin
        repeat ($urandom_range(2, 3)) push_byte(BYTE_ESC);
      end else if (pick < 92) begin
        push_byte(pick_control());
      end else begin
        // broken sequence: cut short by a control byte or junk
        push_byte(BYTE_ESC);
        if ($urandom_range(1)) push_byte(BYTE_LBRACK);
        if ($urandom_range(1)) push_byte(8'($urandom_range(BYTE_ZERO, BYTE_NINE)));
        if ($urandom_range(1)) push_byte(pick_control());
        else push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_if.valid || expected_keys.size() > 0)
      @(negedge clk);
  endtask

  // Driver: sends queued bytes, predicts on each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.byte_in <= '0;
      key_mode      = MODE_IDLE;
      digit_acc     = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        dec_t ev;
        ev = decode_key_byte(in_if.byte_in);
        if (ev.emit) expected_keys.push_back(ev);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() > 0 && !take_break()) begin
          in_if.valid   <= 1'b1;
          in_if.byte_in <= pending_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each event with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        dec_t want;
        if (expected_keys.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind=%0d code=%0d",
                                    out_if.event_kind, out_if.key_code));
        end else begin
          want = expected_keys.pop_front();
          if (out_if.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind %0d, want %0d",
                                      out_if.event_kind, want.event_kind));
          if (out_if.key_code !== want.key_code)
            report_mismatch($sformatf("key_code %0d, want %0d",
                                      out_if.key_code, want.key_code));
        end
      end
      out_if.ready <= !take_break();
    end
  end

  // Cycle counter and timeout
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus phases: directed, then random with a full drain in between
  initial begin
    int waited;
    error_count  = 0;
    bytes_queued = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
    wait_drained();
    queue_random_bytes(RANDOM_FIRST);
    wait_drained();
    queue_random_bytes(RANDOM_SECOND);
    while (pending_bytes.size() > 0 || in_if.valid) @(negedge clk);
    waited = 0;
    while (expected_keys.size() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (5) @(negedge clk);
    if (expected_keys.size() > 0)
      report_mismatch($sformatf("%0d events never arrived", expected_keys.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
